// ----- src/ubx_pkg.sv -----
// shared types and constants of the ubx frame parser
package ubx_pkg;

   // parse phases
   localparam logic [3:0] PH_SYNC1   = 4'd0;
   localparam logic [3:0] PH_SYNC2   = 4'd1;
   localparam logic [3:0] PH_CLASS   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CHECK_A = 4'd7;
   localparam logic [3:0] PH_CHECK_B = 4'd8;

   // sync bytes
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // register indexes
   localparam logic [7:0] REG_NAV_CLASS  = 8'd0;
   localparam logic [7:0] REG_PVT_ID     = 8'd1;
   localparam logic [7:0] REG_STATUS_ID  = 8'd2;
   localparam logic [7:0] REG_ACK_CLASS  = 8'd3;
   localparam logic [7:0] REG_ACK_ID     = 8'd4;
   localparam logic [7:0] REG_NAK_ID     = 8'd5;
   localparam logic [7:0] REG_PVT_MIN    = 8'd6;
   localparam logic [7:0] REG_STATUS_MIN = 8'd7;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // frame status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_CHECKSUM  = 2'd1;
   localparam logic [1:0] ST_TOO_SHORT = 2'd2;
   localparam logic [1:0] ST_UNKNOWN   = 2'd3;

   // message type codes
   localparam logic [2:0] MT_UNKNOWN = 3'd0;
   localparam logic [2:0] MT_PVT     = 3'd1;
   localparam logic [2:0] MT_STATUS  = 3'd2;
   localparam logic [2:0] MT_ACK     = 3'd3;
   localparam logic [2:0] MT_NAK     = 3'd4;

   typedef struct packed {
      logic [7:0]  nav_class_code;
      logic [7:0]  pvt_id_code;
      logic [7:0]  status_id_code;
      logic [7:0]  ack_class_code;
      logic [7:0]  ack_id_code;
      logic [7:0]  nak_id_code;
      logic [15:0] pvt_min_length;
      logic [15:0] status_min_length;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  parse_phase;
      logic [7:0]  sum_a;
      logic [7:0]  sum_b;
      logic [7:0]  frame_class;
      logic [7:0]  frame_id;
      logic [15:0] payload_length;
      logic [15:0] byte_count;
      logic [7:0]  received_check_a;
   } parse_state_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic [15:0] payload_offset;
      logic [1:0]  frame_status;
      logic [2:0]  message_type;
      logic [7:0]  message_class;
      logic [7:0]  message_id;
      logic [15:0] message_length;
   } result_type;

endpackage

// ----- src/ubx_step.sv -----
// next parse state and result for one received byte
module ubx_step #(
   parameter int ACK_MIN_LEN = 2
) (
   input  ubx_pkg::cfg_type         cfg,
   input  ubx_pkg::parse_state_type state_cur,
   input  logic [7:0]               data_byte,
   output ubx_pkg::parse_state_type state_nxt,
   output logic                     res_valid,
   output ubx_pkg::result_type      res
);

   localparam logic [15:0] AckMinLen = 16'(ACK_MIN_LEN);

   logic [7:0]  sum_a_add;
   logic [7:0]  sum_b_add;
   logic [15:0] count_inc;
   logic        nav_hit;
   logic        ack_hit;
   logic        check_ok;
   logic [2:0]  mtype;
   logic [15:0] need;
   logic [1:0]  status;

   assign sum_a_add = state_cur.sum_a + data_byte;
   assign sum_b_add = state_cur.sum_b + sum_a_add;
   assign count_inc = state_cur.byte_count + 16'd1;

   // verdict pieces
   assign nav_hit  = (state_cur.frame_class == cfg.nav_class_code);
   assign ack_hit  = (state_cur.frame_class == cfg.ack_class_code);
   assign check_ok = (state_cur.received_check_a == state_cur.sum_a) &&
                     (data_byte == state_cur.sum_b);

   always_comb begin
      mtype = ubx_pkg::MT_UNKNOWN;
      need  = '0;
      priority if (nav_hit && state_cur.frame_id == cfg.pvt_id_code) begin
         mtype = ubx_pkg::MT_PVT;
         need  = cfg.pvt_min_length;
      end else if (nav_hit && state_cur.frame_id == cfg.status_id_code) begin
         mtype = ubx_pkg::MT_STATUS;
         need  = cfg.status_min_length;
      end else if (ack_hit && state_cur.frame_id == cfg.ack_id_code) begin
         mtype = ubx_pkg::MT_ACK;
         need  = AckMinLen;
      end else if (ack_hit && state_cur.frame_id == cfg.nak_id_code) begin
         mtype = ubx_pkg::MT_NAK;
         need  = AckMinLen;
      end
   end

   always_comb begin
      priority if (!check_ok) begin
         status = ubx_pkg::ST_CHECKSUM;
      end else if (mtype == ubx_pkg::MT_UNKNOWN) begin
         status = ubx_pkg::ST_UNKNOWN;
      end else if (state_cur.payload_length < need) begin
         status = ubx_pkg::ST_TOO_SHORT;
      end else begin
         status = ubx_pkg::ST_OK;
      end
   end

   always_comb begin
      state_nxt = state_cur;
      res_valid = 1'b0;
      res       = '0;
      unique case (state_cur.parse_phase)
         ubx_pkg::PH_SYNC1: begin
            if (data_byte == ubx_pkg::SYNC_FIRST) begin
               state_nxt.parse_phase = ubx_pkg::PH_SYNC2;
            end
         end
         ubx_pkg::PH_SYNC2: begin
            if (data_byte == ubx_pkg::SYNC_SECOND) begin
               state_nxt.parse_phase = ubx_pkg::PH_CLASS;
               state_nxt.sum_a       = '0;
               state_nxt.sum_b       = '0;
            end else if (data_byte != ubx_pkg::SYNC_FIRST) begin
               state_nxt.parse_phase = ubx_pkg::PH_SYNC1;
            end
         end
         ubx_pkg::PH_CLASS: begin
            state_nxt.frame_class = data_byte;
            state_nxt.sum_a       = sum_a_add;
            state_nxt.sum_b       = sum_b_add;
            state_nxt.parse_phase = ubx_pkg::PH_ID;
         end
         ubx_pkg::PH_ID: begin
            state_nxt.frame_id    = data_byte;
            state_nxt.sum_a       = sum_a_add;
            state_nxt.sum_b       = sum_b_add;
            state_nxt.parse_phase = ubx_pkg::PH_LEN_LO;
         end
         ubx_pkg::PH_LEN_LO: begin
            state_nxt.payload_length = {8'd0, data_byte};
            state_nxt.sum_a          = sum_a_add;
            state_nxt.sum_b          = sum_b_add;
            state_nxt.parse_phase    = ubx_pkg::PH_LEN_HI;
         end
         ubx_pkg::PH_LEN_HI: begin
            state_nxt.payload_length = {data_byte, state_cur.payload_length[7:0]};
            state_nxt.sum_a          = sum_a_add;
            state_nxt.sum_b          = sum_b_add;
            state_nxt.byte_count     = '0;
            if (data_byte == 8'd0 && state_cur.payload_length[7:0] == 8'd0) begin
               state_nxt.parse_phase = ubx_pkg::PH_CHECK_A;
            end else begin
               state_nxt.parse_phase = ubx_pkg::PH_PAYLOAD;
            end
         end
         ubx_pkg::PH_PAYLOAD: begin
            state_nxt.sum_a      = sum_a_add;
            state_nxt.sum_b      = sum_b_add;
            state_nxt.byte_count = count_inc;
            if (count_inc >= state_cur.payload_length) begin
               state_nxt.parse_phase = ubx_pkg::PH_CHECK_A;
            end
            res_valid          = 1'b1;
            res.item_kind      = ubx_pkg::KIND_PAYLOAD;
            res.payload_byte   = data_byte;
            res.payload_offset = state_cur.byte_count;
         end
         ubx_pkg::PH_CHECK_A: begin
            state_nxt.received_check_a = data_byte;
            state_nxt.parse_phase      = ubx_pkg::PH_CHECK_B;
         end
         ubx_pkg::PH_CHECK_B: begin
            state_nxt.parse_phase = ubx_pkg::PH_SYNC1;
            res_valid             = 1'b1;
            res.item_kind         = ubx_pkg::KIND_VERDICT;
            res.frame_status      = status;
            res.message_type      = check_ok ? mtype : ubx_pkg::MT_UNKNOWN;
            res.message_class     = state_cur.frame_class;
            res.message_id        = state_cur.frame_id;
            res.message_length    = state_cur.payload_length;
         end
         default: begin
            state_nxt.parse_phase = ubx_pkg::PH_SYNC1;
         end
      endcase
   end

endmodule

// ----- src/ubx_frame_parser.sv -----
// top level of the ubx frame parser: byte stream in, payload bytes and verdicts out
//
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   req_data_byte
// rsp_      out        rsp_valid/rsp_stall   item kind, payload byte/offset, verdict fields
// csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// one byte per cycle sustained when results are not stalled: a byte is held in the
// input register, the parse step runs in the cycle it leaves, and its result lands in
// the output register. the loop that sets the rate is the parse state update. reset
// (synchronous) returns to sync hunt with default codes and needs no clearing pass.
// a stalled result holds the output register and the input register behind it; csr
// writes are always ready.
module ubx_frame_parser #(
   parameter int ACK_MIN_LEN = 2
) (
   input  logic        clock,
   input  logic        reset,
   // received byte stream
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   // payload bytes and frame verdicts
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_payload_offset,
   output logic [1:0]  rsp_frame_status,
   output logic [2:0]  rsp_message_type,
   output logic [7:0]  rsp_message_class,
   output logic [7:0]  rsp_message_id,
   output logic [15:0] rsp_message_length,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   ubx_pkg::cfg_type         cfg_ff;

   // input stage
   logic                     in_vld_ff;
   logic [7:0]               in_byte_ff;

   // parse state
   ubx_pkg::parse_state_type state_ff;
   ubx_pkg::parse_state_type state_in;
   ubx_pkg::parse_state_type state_rst;

   // output stage
   logic                     out_vld_ff;
   ubx_pkg::result_type      out_ff;
   ubx_pkg::result_type      out_in;
   logic                     step_valid;

   logic                     out_free;
   logic                     advance;

   // output register can take a new value when empty or being drained
   assign out_free  = !out_vld_ff || !rsp_stall;
   // the held byte is processed when the result side has room
   assign advance   = in_vld_ff && out_free;
   // input register refills as it empties
   assign req_stall = in_vld_ff && !out_free;
   assign csr_ready = 1'b1;

   // state after reset: hunting for the first sync byte, everything else zero
   always_comb begin
      state_rst             = '0;
      state_rst.parse_phase = ubx_pkg::PH_SYNC1;
   end

   ubx_step #(
      .ACK_MIN_LEN (ACK_MIN_LEN)
   ) u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .data_byte (in_byte_ff),
      .state_nxt (state_in),
      .res_valid (step_valid),
      .res       (out_in)
   );

   // register file, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         // default codes in register order: nav class, pvt id, status id, ack class,
         // ack id, nak id, pvt minimum, status minimum
         cfg_ff <= {8'd1, 8'd7, 8'd3, 8'd5, 8'd1, 8'd0, 16'd92, 16'd16};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ubx_pkg::REG_NAV_CLASS:  cfg_ff.nav_class_code    <= csr_wdata[7:0];
            ubx_pkg::REG_PVT_ID:     cfg_ff.pvt_id_code       <= csr_wdata[7:0];
            ubx_pkg::REG_STATUS_ID:  cfg_ff.status_id_code    <= csr_wdata[7:0];
            ubx_pkg::REG_ACK_CLASS:  cfg_ff.ack_class_code    <= csr_wdata[7:0];
            ubx_pkg::REG_ACK_ID:     cfg_ff.ack_id_code       <= csr_wdata[7:0];
            ubx_pkg::REG_NAK_ID:     cfg_ff.nak_id_code       <= csr_wdata[7:0];
            ubx_pkg::REG_PVT_MIN:    cfg_ff.pvt_min_length    <= csr_wdata;
            ubx_pkg::REG_STATUS_MIN: cfg_ff.status_min_length <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   // input byte, loaded on each request transfer
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // parse state moves once per processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= state_rst;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // output valid: set by a byte that yields a result, cleared when drained
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= advance && step_valid;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (advance && step_valid) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_item_kind      = out_ff.item_kind;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_payload_offset = out_ff.payload_offset;
   assign rsp_frame_status   = out_ff.frame_status;
   assign rsp_message_type   = out_ff.message_type;
   assign rsp_message_class  = out_ff.message_class;
   assign rsp_message_id     = out_ff.message_id;
   assign rsp_message_length = out_ff.message_length;

endmodule
